@@ hw/rtl/vpsc_pkg.sv @@
// Package with the types, codes and constants of the vehicle power state controller.
package vpsc_pkg;

    // Vehicle power modes, as reported in the vehicle_mode field.
    typedef enum logic [1:0] {
        MODE_LV     = 2'd0,
        MODE_HV     = 2'd1,
        MODE_RTD    = 2'd2,
        MODE_FAILED = 2'd3
    } mode_t;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_BUZZER_TICKS = 2'd0,
        CFG_HV_TIMEOUT   = 2'd1,
        CFG_PRESCALE     = 2'd2,
        CFG_UNUSED       = 2'd3
    } cfg_index_t;

    // Field widths.
    localparam int unsigned BUZZER_W    = 10;
    localparam int unsigned HV_W        = 8;
    localparam int unsigned PRESCALE_W  = 8;
    localparam int unsigned CFG_DATA_W  = 10;
    localparam int unsigned IN_FIELDS   = 10;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 8;

    // Register reset values.
    localparam logic [BUZZER_W-1:0]   BUZZER_TICKS_RST = 10'd250;
    localparam logic [HV_W-1:0]       HV_TIMEOUT_RST   = 8'd10;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RST     = 8'd10;

    // Bit positions of the input fields in s_axis_tdata.
    localparam int unsigned IN_INV_INVALID = 0;
    localparam int unsigned IN_INV_ERROR   = 1;
    localparam int unsigned IN_EEPROM_RDY  = 2;
    localparam int unsigned IN_BMS_VALID   = 3;
    localparam int unsigned IN_PRECHARGE   = 4;
    localparam int unsigned IN_BRAKING     = 5;
    localparam int unsigned IN_ACCEL       = 6;
    localparam int unsigned IN_START       = 7;
    localparam int unsigned IN_GPS_VALID   = 8;
    localparam int unsigned IN_PLAUSIBLE   = 9;

endpackage

@@ hw/rtl/vehicle_power_state_controller.sv @@
// Vehicle power state controller: one control tick in, one status result out.
// A tick is held in the input register, and its result in the result register,
// which drives m_axis.
// Throughput: one tick per cycle while m_axis takes results; an input register and
// a result register sit either side of the combinational mode and countdown update.
// Reset: rst_n clears the mode to low voltage, both countdowns, the buzzer and
// the status counter, and loads the configuration registers with their defaults.
module vehicle_power_state_controller
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Tick input.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [0] inverter_invalid [1] inverter_error [2] eeprom_ready [3] bms_valid
    // [4] precharge_done [5] braking [6] accelerating [7] start_pressed
    // [8] gps_valid [9] torque_plausible [15:10] zero
    input  logic [vpsc_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Status result output.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [1:0] vehicle_mode [2] cooling_on [3] buzzer_on [4] fault_lamp
    // [5] brake_lamp [6] send_status [7] zero
    output logic [vpsc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Configuration write channel.
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [1:0]                            cfg_index,
    input  logic [vpsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers.
    logic [vpsc_pkg::BUZZER_W-1:0]   buzzer_ticks_reg;
    logic [vpsc_pkg::HV_W-1:0]       hv_timeout_reg;
    logic [vpsc_pkg::PRESCALE_W-1:0] prescale_reg;

    // Input stage.
    logic                            in_valid_reg;
    logic [vpsc_pkg::IN_FIELDS-1:0]  in_data_reg;

    // Tick state.
    vpsc_pkg::mode_t                 mode_reg, mode_next;
    logic [vpsc_pkg::HV_W-1:0]       hv_cnt_reg, hv_cnt_next;
    logic [vpsc_pkg::BUZZER_W-1:0]   bz_cnt_reg, bz_cnt_next;
    logic                            buzzer_reg, buzzer_next;
    logic [vpsc_pkg::PRESCALE_W-1:0] status_cnt_reg, status_cnt_next;

    // Result stage.
    logic                            out_valid_reg;
    logic [vpsc_pkg::OUT_TDATA_W-1:0] out_data_reg, out_data_next;

    // Decoded tick fields and intermediate values.
    logic                            advance;
    logic                            inv_invalid, inv_error, eeprom_ok, precharge;
    logic                            brk, accel, start, gps_ok, plausible;
    logic                            rtd_entry;
    logic [vpsc_pkg::HV_W-1:0]       hv_dec;
    logic [vpsc_pkg::BUZZER_W-1:0]   bz_dec;
    logic [vpsc_pkg::PRESCALE_W-1:0] status_inc;
    vpsc_pkg::mode_t                 mode_entry;
    logic                            send, fault, cooling;

    // A tick moves on when the result register is empty or being emptied.
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign cfg_ready     = 1'b1;

    assign inv_invalid = in_data_reg[vpsc_pkg::IN_INV_INVALID];
    assign inv_error   = in_data_reg[vpsc_pkg::IN_INV_ERROR];
    assign eeprom_ok   = in_data_reg[vpsc_pkg::IN_EEPROM_RDY];
    assign precharge   = in_data_reg[vpsc_pkg::IN_BMS_VALID]
                         && in_data_reg[vpsc_pkg::IN_PRECHARGE];
    assign brk         = in_data_reg[vpsc_pkg::IN_BRAKING];
    assign accel       = in_data_reg[vpsc_pkg::IN_ACCEL];
    assign start       = in_data_reg[vpsc_pkg::IN_START];
    assign gps_ok      = in_data_reg[vpsc_pkg::IN_GPS_VALID];
    assign plausible   = in_data_reg[vpsc_pkg::IN_PLAUSIBLE];

    // Countdowns drop by one and stop at zero.
    assign hv_dec = (hv_cnt_reg != '0) ? hv_cnt_reg - 1'b1 : hv_cnt_reg;
    assign bz_dec = (bz_cnt_reg != '0) ? bz_cnt_reg - 1'b1 : bz_cnt_reg;

    // Mode at the start of the tick: failed falls back, faults force failed.
    always_comb
    begin
        mode_entry = (mode_reg == vpsc_pkg::MODE_FAILED) ? vpsc_pkg::MODE_LV : mode_reg;
        if (inv_invalid || !eeprom_ok)
        begin
            mode_entry = vpsc_pkg::MODE_FAILED;
        end
    end

    assign rtd_entry = (mode_entry == vpsc_pkg::MODE_HV) && brk && !accel && start;

    // Next mode.
    always_comb
    begin
        mode_next = mode_entry;
        unique case (mode_entry)
            vpsc_pkg::MODE_LV:
            begin
                if (precharge)
                begin
                    mode_next = vpsc_pkg::MODE_HV;
                end
            end
            vpsc_pkg::MODE_HV, vpsc_pkg::MODE_RTD:
            begin
                if (!precharge && hv_dec == '0)
                begin
                    mode_next = vpsc_pkg::MODE_LV;
                end
                else if (rtd_entry)
                begin
                    mode_next = vpsc_pkg::MODE_RTD;
                end
            end
            vpsc_pkg::MODE_FAILED:
            begin
                mode_next = vpsc_pkg::MODE_FAILED;
            end
            default:
            begin
                mode_next = vpsc_pkg::MODE_LV;
            end
        endcase
    end

    // Countdowns, buzzer, status counter and the result word.
    always_comb
    begin
        hv_cnt_next = hv_dec;
        bz_cnt_next = bz_dec;
        buzzer_next = buzzer_reg;
        if (rtd_entry)
        begin
            buzzer_next = 1'b1;
            bz_cnt_next = buzzer_ticks_reg;
        end
        if ((mode_entry == vpsc_pkg::MODE_HV || mode_entry == vpsc_pkg::MODE_RTD)
            && precharge)
        begin
            hv_cnt_next = hv_timeout_reg;
        end
        if (bz_cnt_next == '0)
        begin
            buzzer_next = 1'b0;
        end

        status_inc      = status_cnt_reg + 1'b1;
        send            = (status_inc >= prescale_reg);
        status_cnt_next = send ? '0 : status_inc;

        cooling = (mode_next == vpsc_pkg::MODE_HV) || (mode_next == vpsc_pkg::MODE_RTD);
        fault   = !plausible || (mode_next == vpsc_pkg::MODE_FAILED) || inv_error || !gps_ok;

        out_data_next = {1'b0, send, brk, fault, buzzer_next, cooling, mode_next};
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buzzer_ticks_reg <= vpsc_pkg::BUZZER_TICKS_RST;
            hv_timeout_reg   <= vpsc_pkg::HV_TIMEOUT_RST;
            prescale_reg     <= vpsc_pkg::PRESCALE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (vpsc_pkg::cfg_index_t'(cfg_index))
                vpsc_pkg::CFG_BUZZER_TICKS: buzzer_ticks_reg <= cfg_data;
                vpsc_pkg::CFG_HV_TIMEOUT:   hv_timeout_reg   <= cfg_data[vpsc_pkg::HV_W-1:0];
                vpsc_pkg::CFG_PRESCALE:     prescale_reg <= cfg_data[vpsc_pkg::PRESCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input and result valid flags and tick state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            mode_reg       <= vpsc_pkg::MODE_LV;
            hv_cnt_reg     <= '0;
            bz_cnt_reg     <= '0;
            buzzer_reg     <= 1'b0;
            status_cnt_reg <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                mode_reg       <= mode_next;
                hv_cnt_reg     <= hv_cnt_next;
                bz_cnt_reg     <= bz_cnt_next;
                buzzer_reg     <= buzzer_next;
                status_cnt_reg <= status_cnt_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_data_reg <= s_axis_tdata[vpsc_pkg::IN_FIELDS-1:0];
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // The buzzer is only on while its countdown is running.
    a_buzzer_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        buzzer_reg |-> (bz_cnt_reg != '0))
        else $error("buzzer on with expired countdown");

    // A failed mode does not persist unless a fault is present again.
    a_failed_recovers: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && mode_reg == vpsc_pkg::MODE_FAILED && !inv_invalid && eeprom_ok)
        |=> (mode_reg != vpsc_pkg::MODE_FAILED))
        else $error("failed mode did not fall back");

    // Back-pressure to the input only while a tick is held in the input stage.
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a held tick");

    // Cooling in the result follows the reported mode.
    a_cooling: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg[2] ==
            (out_data_reg[1:0] == vpsc_pkg::MODE_HV || out_data_reg[1:0] == vpsc_pkg::MODE_RTD)))
        else $error("cooling drive disagrees with mode");

endmodule

@@ tb/tb_vehicle_power_state_controller.sv @@
// Self-checking testbench for the vehicle power state controller.
module tb_vehicle_power_state_controller;

    // Tick flags, declared so that the last field sits in bit 0 as on s_axis_tdata.
    typedef struct packed {
        logic torque_plausible;
        logic gps_valid;
        logic start_pressed;
        logic accelerating;
        logic braking;
        logic precharge_done;
        logic bms_valid;
        logic eeprom_ready;
        logic inverter_error;
        logic inverter_invalid;
    } tick_t;

    // Status fields, declared so that vehicle_mode sits in the lowest bits as on m_axis_tdata.
    typedef struct packed {
        logic            send_status;
        logic            brake_lamp;
        logic            fault_lamp;
        logic            buzzer_on;
        logic            cooling_on;
        vpsc_pkg::mode_t vehicle_mode;
    } status_t;

    // Kinds of row in the directed script.
    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_CHK,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        vpsc_pkg::cfg_index_t idx;
        logic [9:0]           value;
        status_t              want;
    } row_t;

    localparam int unsigned SCRIPT_ROWS    = 32;
    localparam int unsigned PHASES         = 12;
    localparam int unsigned PHASE_ITEMS    = 112;
    localparam int unsigned LONG_HOLD      = 80;
    localparam int unsigned PIPE_SETTLE    = 4;
    localparam int unsigned WATCHDOG_LIMIT = 1000;

    // Single-flag masks at the package bit positions.
    localparam logic [9:0] F_INVALID = 10'd1 << vpsc_pkg::IN_INV_INVALID;
    localparam logic [9:0] F_INV_ERR = 10'd1 << vpsc_pkg::IN_INV_ERROR;
    localparam logic [9:0] F_EEPROM  = 10'd1 << vpsc_pkg::IN_EEPROM_RDY;
    localparam logic [9:0] F_BMS     = 10'd1 << vpsc_pkg::IN_BMS_VALID;
    localparam logic [9:0] F_PRE     = 10'd1 << vpsc_pkg::IN_PRECHARGE;
    localparam logic [9:0] F_BRK     = 10'd1 << vpsc_pkg::IN_BRAKING;
    localparam logic [9:0] F_ACC     = 10'd1 << vpsc_pkg::IN_ACCEL;
    localparam logic [9:0] F_START   = 10'd1 << vpsc_pkg::IN_START;
    localparam logic [9:0] F_GPS     = 10'd1 << vpsc_pkg::IN_GPS_VALID;
    localparam logic [9:0] F_PLAUS   = 10'd1 << vpsc_pkg::IN_PLAUSIBLE;
    localparam logic [9:0] F_OK      = F_EEPROM | F_GPS | F_PLAUS;
    localparam logic [9:0] F_CHARGED = F_OK | F_BMS | F_PRE;

    logic                             clk;
    logic                             rst_n         = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [vpsc_pkg::IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [vpsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_valid     = 1'b0;
    logic                             cfg_ready;
    logic [1:0]                       cfg_index     = '0;
    logic [vpsc_pkg::CFG_DATA_W-1:0]  cfg_data      = '0;

    // Predicted state of the controller and its registers.
    vpsc_pkg::mode_t mode_now;
    logic [7:0]      hv_left;
    logic [9:0]      buzz_left;
    logic            buzz_on;
    logic [7:0]      tick_count;
    logic [9:0]      buzz_len;
    logic [7:0]      hv_len;
    logic [7:0]      prescale_len;

    status_t       pending_status[$];
    int unsigned   error_count = 0;
    int unsigned   idle_cycles = 0;
    int unsigned   tx_max      = 13;
    int unsigned   rx_max      = 13;
    bit            burst_on    = 1'b0;
    row_t          script[0:SCRIPT_ROWS-1];

    vehicle_power_state_controller dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Advances the predicted state by one control tick and returns the status it reports.
    function automatic status_t predict_tick(input tick_t t);
        status_t r;
        logic    charged;
        charged = t.bms_valid & t.precharge_done;
        // Both deadlines count down first, whatever the mode.
        if (hv_left != 0)
            hv_left = hv_left - 8'd1;
        if (buzz_left != 0)
            buzz_left = buzz_left - 10'd1;
        if (mode_now == vpsc_pkg::MODE_FAILED)
            mode_now = vpsc_pkg::MODE_LV;
        if (t.inverter_invalid || !t.eeprom_ready)
            mode_now = vpsc_pkg::MODE_FAILED;
        if (mode_now == vpsc_pkg::MODE_LV)
        begin
            if (charged)
                mode_now = vpsc_pkg::MODE_HV;
        end
        else if (mode_now != vpsc_pkg::MODE_FAILED)
        begin
            if (mode_now == vpsc_pkg::MODE_HV && t.braking && !t.accelerating
                && t.start_pressed)
            begin
                mode_now  = vpsc_pkg::MODE_RTD;
                buzz_on   = 1'b1;
                buzz_left = buzz_len;
            end
            // Precharge keeps the deadline fresh; once it has passed, drop to low voltage.
            if (charged)
                hv_left = hv_len;
            else if (hv_left == 0)
                mode_now = vpsc_pkg::MODE_LV;
        end
        if (buzz_left == 0)
            buzz_on = 1'b0;
        tick_count    = tick_count + 8'd1;
        r.send_status = 1'b0;
        if (tick_count >= prescale_len)
        begin
            r.send_status = 1'b1;
            tick_count    = 8'd0;
        end
        r.vehicle_mode = mode_now;
        r.cooling_on   = (mode_now == vpsc_pkg::MODE_HV) || (mode_now == vpsc_pkg::MODE_RTD);
        r.buzzer_on    = buzz_on;
        r.fault_lamp   = !t.torque_plausible || mode_now == vpsc_pkg::MODE_FAILED
                         || t.inverter_error || !t.gps_valid;
        r.brake_lamp   = t.braking;
        return r;
    endfunction

    function automatic row_t row_tick(input logic [9:0] flags);
        row_t r;
        r       = '0;
        r.kind  = ROW_TICK;
        r.value = flags;
        return r;
    endfunction

    function automatic row_t row_chk(input logic [9:0] flags, input vpsc_pkg::mode_t m,
                                     input logic cool, input logic buzz, input logic fault,
                                     input logic brake, input logic send);
        row_t r;
        r       = '0;
        r.kind  = ROW_CHK;
        r.value = flags;
        r.want  = '{send, brake, fault, buzz, cool, m};
        return r;
    endfunction

    function automatic row_t row_cfg(input vpsc_pkg::cfg_index_t idx, input logic [9:0] val);
        row_t r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.idx   = idx;
        r.value = val;
        return r;
    endfunction

    // Mostly healthy ticks with random pedals and precharge, plus some raw noise.
    function automatic tick_t random_tick(input int unsigned pre_pct);
        tick_t      t;
        logic [1:0] partial;
        if ($urandom_range(99) < 8)
            return tick_t'(10'($urandom));
        t.inverter_invalid = ($urandom_range(99) < 2);
        t.inverter_error   = ($urandom_range(99) < 10);
        t.eeprom_ready     = ($urandom_range(99) >= 2);
        if ($urandom_range(99) < pre_pct)
        begin
            t.bms_valid      = 1'b1;
            t.precharge_done = 1'b1;
        end
        else
        begin
            partial          = 2'($urandom_range(2));
            t.bms_valid      = partial[0];
            t.precharge_done = partial[1];
        end
        t.braking          = 1'($urandom_range(1));
        t.accelerating     = ($urandom_range(99) < 30);
        t.start_pressed    = ($urandom_range(99) < 35);
        t.gps_valid        = ($urandom_range(99) >= 10);
        t.torque_plausible = ($urandom_range(99) >= 10);
        return t;
    endfunction

    // Register value for a phase: the extremes, zero, raw data or a short count.
    function automatic logic [9:0] pick_setting(input logic [9:0] top);
        case ($urandom_range(5))
            0:       return 10'd1;
            1:       return top;
            2:       return 10'd0;
            3:       return 10'($urandom);
            default: return 10'($urandom_range(20, 1));
        endcase
    endfunction

    // Offers one tick after a random gap (none while burst_on is set) and records its expected status on transfer.
    task automatic send_tick(input tick_t t, input bit typed, input status_t want);
        int unsigned gap;
        status_t     guess;
        gap = burst_on ? 0 : $urandom_range(tx_max, 0);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, t};
        do
            @(posedge clk);
        while (!s_axis_tready);
        guess = predict_tick(t);
        pending_status.push_back(typed ? want : guess);
    endtask

    // Stops offering ticks until every expected status has arrived and the pipeline is empty.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (PIPE_SETTLE) @(posedge clk);
    endtask

    // One register write transfer; the predictor follows on acceptance.
    task automatic write_reg(input vpsc_pkg::cfg_index_t idx, input logic [9:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            vpsc_pkg::CFG_BUZZER_TICKS: buzz_len     = val;
            vpsc_pkg::CFG_HV_TIMEOUT:   hv_len       = val[7:0];
            vpsc_pkg::CFG_PRESCALE:     prescale_len = val[7:0];
            default:                    ;
        endcase
        @(posedge clk);
    endtask

    // Main sequence: reset, directed script, then randomised phases.
    initial
    begin
        int unsigned pre_pct;
        mode_now     = vpsc_pkg::MODE_LV;
        hv_left      = '0;
        buzz_left    = '0;
        buzz_on      = 1'b0;
        tick_count   = '0;
        buzz_len     = vpsc_pkg::BUZZER_TICKS_RST;
        hv_len       = vpsc_pkg::HV_TIMEOUT_RST;
        prescale_len = vpsc_pkg::PRESCALE_RST;

        script = '{
            row_chk(F_OK,         vpsc_pkg::MODE_LV,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            row_chk(10'h3FF,      vpsc_pkg::MODE_FAILED, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0),
            row_chk(10'h000,      vpsc_pkg::MODE_FAILED, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0),
            row_chk(F_OK | F_BMS, vpsc_pkg::MODE_LV,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            row_chk(F_OK | F_PRE, vpsc_pkg::MODE_LV,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            row_chk(F_CHARGED,    vpsc_pkg::MODE_HV,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
            // Deadline never loaded on entry, so losing precharge drops at once.
            row_chk(F_OK,         vpsc_pkg::MODE_LV,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            row_chk(F_CHARGED,    vpsc_pkg::MODE_HV,     1'b1, 1'b0, 1'b0, 1'b0, 1'b0),
            row_tick(F_CHARGED),
            // Accelerator held blocks ready-to-drive; tenth tick sends status.
            row_chk(F_CHARGED | F_BRK | F_START | F_ACC,
                                  vpsc_pkg::MODE_HV,     1'b1, 1'b0, 1'b0, 1'b1, 1'b1),
            row_tick(F_OK | F_BRK | F_START),
            row_tick(F_OK | F_ACC),
            row_tick(F_OK | F_INV_ERR),
            row_tick(F_OK & ~F_GPS),
            row_tick(F_OK & ~F_PLAUS),
            row_tick(F_OK | F_INVALID),
            row_tick(F_OK),
            // Zero buzzer time, zero prescale and the longest HV deadline; a write to the spare index is ignored.
            row_cfg(vpsc_pkg::CFG_BUZZER_TICKS, 10'd0),
            row_cfg(vpsc_pkg::CFG_PRESCALE,     10'd0),
            row_cfg(vpsc_pkg::CFG_HV_TIMEOUT,   10'd255),
            row_cfg(vpsc_pkg::CFG_UNUSED,       10'h3FF),
            row_tick(F_CHARGED),
            row_tick(F_CHARGED),
            row_tick(F_OK | F_BRK | F_START),
            row_cfg(vpsc_pkg::CFG_BUZZER_TICKS, 10'd1023),
            row_cfg(vpsc_pkg::CFG_HV_TIMEOUT,   10'd1),
            row_cfg(vpsc_pkg::CFG_PRESCALE,     10'd255),
            row_tick(F_CHARGED),
            row_tick(F_OK),
            row_tick(F_CHARGED),
            row_tick(F_CHARGED | F_BRK | F_START),
            row_tick(F_OK | F_BRK | F_START)
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script.
        foreach (script[i])
        begin
            case (script[i].kind)
                ROW_CFG:
                begin
                    drain();
                    write_reg(script[i].idx, script[i].value);
                end
                ROW_TICK: send_tick(tick_t'(script[i].value), 1'b0, '0);
                default:  send_tick(tick_t'(script[i].value), 1'b1, script[i].want);
            endcase
        end

        // Random phases, each with its own settings and idling pattern.
        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            write_reg(vpsc_pkg::CFG_BUZZER_TICKS, pick_setting(10'd1023));
            write_reg(vpsc_pkg::CFG_HV_TIMEOUT, pick_setting(10'd255));
            write_reg(vpsc_pkg::CFG_PRESCALE, pick_setting(10'd255));
            if ($urandom_range(3) == 0)
                write_reg(vpsc_pkg::CFG_UNUSED, 10'($urandom));
            case (p % 4)
                0:       begin tx_max = 13; rx_max = 13; end
                1:       begin tx_max = 0;  rx_max = 0;  end
                2:       begin tx_max = 0;  rx_max = 13; end
                default: begin tx_max = 13; rx_max = 0;  end
            endcase
            case (p % 3)
                0:       pre_pct = 95;
                1:       pre_pct = 75;
                default: pre_pct = 45;
            endcase
            burst_on = (p == 5);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_tick(random_tick(pre_pct), 1'b0, '0);
                if (!burst_on && $urandom_range(59) == 0)
                    drain();
            end
            burst_on = 1'b0;
        end

        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Status receiver: random stalls, one long hold-off during the burst phase.
    initial
    begin
        int unsigned stall;
        bit          held_long;
        status_t     got;
        status_t     want;
        held_long = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = $urandom_range(rx_max, 0);
            if (burst_on && !held_long)
            begin
                stall     = LONG_HOLD;
                held_long = 1'b1;
            end
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            got = status_t'(m_axis_tdata[6:0]);
            if (pending_status.size() == 0)
            begin
                $error("status transfer with nothing expected: %h", m_axis_tdata);
                error_count++;
            end
            else
            begin
                want = pending_status.pop_front();
                if (got.vehicle_mode !== want.vehicle_mode)
                begin
                    $error("vehicle_mode: expected %0d, got %0d", want.vehicle_mode,
                           got.vehicle_mode);
                    error_count++;
                end
                if (got.cooling_on !== want.cooling_on)
                begin
                    $error("cooling_on: expected %0b, got %0b", want.cooling_on, got.cooling_on);
                    error_count++;
                end
                if (got.buzzer_on !== want.buzzer_on)
                begin
                    $error("buzzer_on: expected %0b, got %0b", want.buzzer_on, got.buzzer_on);
                    error_count++;
                end
                if (got.fault_lamp !== want.fault_lamp)
                begin
                    $error("fault_lamp: expected %0b, got %0b", want.fault_lamp, got.fault_lamp);
                    error_count++;
                end
                if (got.brake_lamp !== want.brake_lamp)
                begin
                    $error("brake_lamp: expected %0b, got %0b", want.brake_lamp, got.brake_lamp);
                    error_count++;
                end
                if (got.send_status !== want.send_status)
                begin
                    $error("send_status: expected %0b, got %0b", want.send_status,
                           got.send_status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on any channel for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule
